FILE: sv/mcr_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer package
// Shared types, constants and the sequencer microcode.
// ----------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

  // display defaults
  localparam int DISP_W_DEF = 128;
  localparam int DISP_H_DEF = 64;

  // field and datapath widths
  localparam int COORD_W  = 8;
  localparam int RAD_W    = 11;   // signed radius through the clip stages
  localparam int STEP_Y_W = 9;    // signed step y, reaches -1
  localparam int DEC_W    = 12;   // signed decision term
  localparam int MAX_SETS = 32;   // point sets per circle at most
  localparam int CNT_W    = $clog2(MAX_SETS);

  // request and point set transactions
  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] radius;
  } req_t;

  typedef struct packed {
    logic [COORD_W-1:0] col_plus_dx;
    logic [COORD_W-1:0] col_minus_dx;
    logic [COORD_W-1:0] col_plus_dy;
    logic [COORD_W-1:0] col_minus_dy;
    logic [COORD_W-1:0] row_plus_dy;
    logic [COORD_W-1:0] row_minus_dy;
    logic [COORD_W-1:0] row_plus_dx;
    logic [COORD_W-1:0] row_minus_dx;
    logic               last;
  } pset_t;

  // microcode
  localparam int UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UA_WAIT  = 3'd0;
  localparam upc_t UA_CLIPC = 3'd1;
  localparam upc_t UA_CLIPR = 3'd2;
  localparam upc_t UA_INIT  = 3'd3;
  localparam upc_t UA_EMIT  = 3'd4;

  // branch condition: taken moves to target, otherwise the step repeats
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN_TAKEN,
    COND_LAST_SENT
  } cond_t;

  typedef struct packed {
    logic  take_in;
    logic  clip_col;
    logic  clip_row;
    logic  init;
    logic  emit;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic in_taken;
    logic last_sent;
  } seq_stat_t;

  function automatic uword_t ucode(input upc_t upc);
    uword_t w;
    w = '{take_in: 1'b1, clip_col: 1'b0, clip_row: 1'b0, init: 1'b0, emit: 1'b0,
          cond: COND_IN_TAKEN, target: UA_CLIPC};
    case (upc)
      UA_WAIT: begin
        w = '{take_in: 1'b1, clip_col: 1'b0, clip_row: 1'b0, init: 1'b0, emit: 1'b0,
              cond: COND_IN_TAKEN, target: UA_CLIPC};
      end
      UA_CLIPC: begin
        w = '{take_in: 1'b0, clip_col: 1'b1, clip_row: 1'b0, init: 1'b0, emit: 1'b0,
              cond: COND_ALWAYS, target: UA_CLIPR};
      end
      UA_CLIPR: begin
        w = '{take_in: 1'b0, clip_col: 1'b0, clip_row: 1'b1, init: 1'b0, emit: 1'b0,
              cond: COND_ALWAYS, target: UA_INIT};
      end
      UA_INIT: begin
        w = '{take_in: 1'b0, clip_col: 1'b0, clip_row: 1'b0, init: 1'b1, emit: 1'b0,
              cond: COND_ALWAYS, target: UA_EMIT};
      end
      UA_EMIT: begin
        w = '{take_in: 1'b0, clip_col: 1'b0, clip_row: 1'b0, init: 1'b0, emit: 1'b1,
              cond: COND_LAST_SENT, target: UA_WAIT};
      end
      default: begin
        w = '{take_in: 1'b0, clip_col: 1'b0, clip_row: 1'b0, init: 1'b0, emit: 1'b0,
              cond: COND_ALWAYS, target: UA_WAIT};
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: sv/mcr_seq.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer sequencer
// Step counter over the microcode table with conditional branches.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  mcr_pkg::seq_stat_t stat,
  output mcr_pkg::uword_t    uw
);
  import mcr_pkg::*;

  upc_t upc_r;
  upc_t upc_nxt;
  logic go;

  assign uw = ucode(upc_r);

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:    go = 1'b1;
      COND_IN_TAKEN:  go = stat.in_taken;
      COND_LAST_SENT: go = stat.last_sent;
      default:        go = 1'b1;
    endcase
    upc_nxt = go ? uw.target : upc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer
// Clips a circle request to the display and emits its octant point sets.
// ----------------------------------------------------------------------------
// Steps after the request transaction: clip columns, clip rows, set up, then
//   emit, which loads the first point set into the output register.
// Throughput: one point set per cycle from the emit step while the output
//   is not stalled; a circle has N sets (N <= 32), and the next request is
//   taken only after the final set of the circle is sent.
// Reset: synchronous active-low; step counter to the wait step, output empty.
`default_nettype none

module midpoint_circle_rasterizer #(
  parameter int DISPLAY_WIDTH  = mcr_pkg::DISP_W_DEF,
  parameter int DISPLAY_HEIGHT = mcr_pkg::DISP_H_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mcr_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mcr_pkg::pset_t out_data
);
  import mcr_pkg::*;

  localparam logic signed [RAD_W-1:0]    X_MAX  = RAD_W'(DISPLAY_WIDTH - 1);
  localparam logic signed [RAD_W-1:0]    Y_MAX  = RAD_W'(DISPLAY_HEIGHT - 1);
  localparam logic signed [RAD_W-1:0]    R_ONE  = RAD_W'(1);
  localparam logic signed [STEP_Y_W-1:0] Y_ONE  = STEP_Y_W'(1);
  localparam logic signed [DEC_W-1:0]    D_3    = DEC_W'(3);
  localparam logic signed [DEC_W-1:0]    D_6    = DEC_W'(6);
  localparam logic signed [DEC_W-1:0]    D_10   = DEC_W'(10);
  localparam logic [CNT_W-1:0]           CNT_LAST = CNT_W'(MAX_SETS - 2);

  uword_t    uw;
  seq_stat_t stat;

  // circle state
  logic [COORD_W-1:0]         cx_r, cy_r;
  logic signed [RAD_W-1:0]    rad_r;
  logic [COORD_W-1:0]         x_r;
  logic signed [STEP_Y_W-1:0] y_r;
  logic signed [DEC_W-1:0]    d_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       last_r;

  // output register
  logic  out_valid_r;
  pset_t out_data_r;

  logic in_taken, can_load, emit_fire;

  logic signed [RAD_W-1:0]    cx_w, cy_w;
  logic signed [RAD_W-1:0]    col_hi, col_lo, row_hi, row_lo;
  logic signed [RAD_W-1:0]    rad_col, rad_row, rad_m1;
  logic                       rad_pos;
  logic signed [DEC_W-1:0]    d_init;

  logic [COORD_W-1:0]         x_inc;
  logic signed [STEP_Y_W-1:0] y_dec, y_nxt, x_cmp;
  logic signed [DEC_W-1:0]    x_ext, y_ext, d_nxt;
  logic                       d_pos, last_nxt;
  pset_t                      pset;

  mcr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .uw    (uw)
  );

  assign in_stall  = !uw.take_in;
  assign in_taken  = uw.take_in && in_valid;
  assign can_load  = !out_valid_r || !out_stall;
  assign emit_fire = uw.emit && can_load;

  assign stat = '{in_taken: in_taken, last_sent: emit_fire && last_r};

  // clipping, signed compares
  assign cx_w   = $signed({{(RAD_W-COORD_W){1'b0}}, cx_r});
  assign cy_w   = $signed({{(RAD_W-COORD_W){1'b0}}, cy_r});
  assign col_hi = cx_w + rad_r - R_ONE;
  assign col_lo = cx_w - rad_r + R_ONE;
  assign row_hi = cy_w + rad_r - R_ONE;
  assign row_lo = cy_w - rad_r + R_ONE;

  always_comb begin
    if (col_hi > X_MAX) begin
      rad_col = X_MAX - cx_w;
    end else if (col_lo[RAD_W-1]) begin
      rad_col = cx_w + R_ONE;
    end else begin
      rad_col = rad_r;
    end
    if (row_hi > Y_MAX) begin
      rad_row = Y_MAX - cy_w;
    end else if (row_lo[RAD_W-1]) begin
      rad_row = cy_w + R_ONE;
    end else begin
      rad_row = rad_r;
    end
  end

  // loop set-up: y = r-1, d = 3-2r
  assign rad_pos = !rad_r[RAD_W-1] && (|rad_r);
  assign rad_m1  = rad_r - R_ONE;
  assign d_init  = D_3 - $signed(DEC_W'({rad_r, 1'b0}));

  // one midpoint step
  always_comb begin
    x_inc = x_r + COORD_W'(1);
    y_dec = y_r - Y_ONE;
    x_ext = $signed({{(DEC_W-COORD_W){1'b0}}, x_inc});
    y_ext = $signed({{(DEC_W-STEP_Y_W){y_dec[STEP_Y_W-1]}}, y_dec});
    d_pos = !d_r[DEC_W-1] && (|d_r);
    if (d_pos) begin
      y_nxt = y_dec;
      d_nxt = d_r + ((x_ext - y_ext) <<< 2) + D_10;
    end else begin
      y_nxt = y_r;
      d_nxt = d_r + (x_ext <<< 2) + D_6;
    end
    x_cmp    = $signed({{(STEP_Y_W-COORD_W){1'b0}}, x_inc});
    last_nxt = (y_nxt < x_cmp) || (cnt_r == CNT_LAST);
  end

  // octant coordinates of the current step, modulo 256
  always_comb begin
    pset.col_plus_dx  = cx_r + x_r;
    pset.col_minus_dx = cx_r - x_r;
    pset.col_plus_dy  = cx_r + y_r[COORD_W-1:0];
    pset.col_minus_dy = cx_r - y_r[COORD_W-1:0];
    pset.row_plus_dy  = cy_r + y_r[COORD_W-1:0];
    pset.row_minus_dy = cy_r - y_r[COORD_W-1:0];
    pset.row_plus_dx  = cy_r + x_r;
    pset.row_minus_dx = cy_r - x_r;
    pset.last         = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_taken) begin
      cx_r  <= in_data.center_x;
      cy_r  <= in_data.center_y;
      rad_r <= $signed({{(RAD_W-COORD_W){1'b0}}, in_data.radius});
    end
    if (uw.clip_col) begin
      rad_r <= rad_col;
    end
    if (uw.clip_row) begin
      rad_r <= rad_row;
    end
    if (uw.init) begin
      x_r   <= '0;
      cnt_r <= '0;
      if (rad_pos) begin
        y_r    <= rad_m1[STEP_Y_W-1:0];
        d_r    <= d_init;
        last_r <= 1'b0;
      end else begin
        // centre off the display or zero radius: single set at the centre
        y_r    <= '0;
        d_r    <= '0;
        last_r <= 1'b1;
      end
    end
    if (emit_fire) begin
      out_data_r <= pset;
      x_r        <= x_inc;
      y_r        <= y_nxt;
      d_r        <= d_nxt;
      last_r     <= last_nxt;
      cnt_r      <= cnt_r + CNT_W'(1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: sv/mcr_checker.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input mcr_pkg::pset_t out_data
);
  import mcr_pkg::*;

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a held point set stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled point set changed");

  // one circle at a time: a request transaction closes the input
  a_in_closed: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && !in_stall |=> in_stall)
    else $error("request taken while circle set-up runs");

  // while a non-final point set is held, the final one is still to come
  a_mid_circle: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_data.last |-> in_stall)
    else $error("request taken before final point set");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: verif/midpoint_circle_rasterizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer testbench
// Sends circle requests under random sender and receiver idling. An
// in-bench model clips each request and walks the midpoint loop, then every
// point set that comes out is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_tb;
  import mcr_pkg::*;

  localparam int DISP_W       = DISP_W_DEF;
  localparam int DISP_H       = DISP_H_DEF;
  localparam int DRAIN_CYCLES = 16;
  localparam int RAND_PER_PHASE = 48;

  class circle_scoreboard;
    pset_t       pending_sets[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function pset_t point_set(int cx, int cy, int x, int y, bit last);
      pset_t s;
      s.col_plus_dx  = COORD_W'(cx + x);
      s.col_minus_dx = COORD_W'(cx - x);
      s.col_plus_dy  = COORD_W'(cx + y);
      s.col_minus_dy = COORD_W'(cx - y);
      s.row_plus_dy  = COORD_W'(cy + y);
      s.row_minus_dy = COORD_W'(cy - y);
      s.row_plus_dx  = COORD_W'(cy + x);
      s.row_minus_dx = COORD_W'(cy - x);
      s.last         = last;
      return s;
    endfunction

    // Clip the radius, then queue every point set the circle should produce
    function void rasterize_circle(req_t rq);
      int                      cx;
      int                      cy;
      int                      r;
      int                      x;
      int                      y;
      int                      n;
      logic signed [DEC_W-1:0] d;
      bit                      done;
      cx = rq.center_x;
      cy = rq.center_y;
      r  = rq.radius;
      if (cx + r - 1 > DISP_W - 1) begin
        r = DISP_W - 1 - cx;
      end else if (cx - (r - 1) < 0) begin
        r = cx + 1;
      end
      if (cy + r - 1 > DISP_H - 1) begin
        r = DISP_H - 1 - cy;
      end else if (cy - (r - 1) < 0) begin
        r = cy + 1;
      end
      // centre off the display or zero radius: single set at the centre
      if (r <= 0) begin
        pending_sets.push_back(point_set(cx, cy, 0, 0, 1'b1));
        return;
      end
      x = 0;
      y = r - 1;
      d = DEC_W'(3 - 2 * r);
      pending_sets.push_back(point_set(cx, cy, x, y, 1'b0));
      n = 1;
      while (y >= x) begin
        x++;
        if (d > 0) begin
          y--;
          d = DEC_W'(d + 4 * (x - y) + 10);
        end else begin
          d = DEC_W'(d + 4 * x + 6);
        end
        // long circles are cut off after MAX_SETS sets
        done = (y < x) || (n == MAX_SETS - 1);
        pending_sets.push_back(point_set(cx, cy, x, y, done));
        n++;
        if (done) break;
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_point_set(pset_t got);
      pset_t want;
      if (pending_sets.size() == 0) begin
        $display("%0t: unexpected point set, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_sets.pop_front();
      compare_field("col_plus_dx",  want.col_plus_dx,  got.col_plus_dx);
      compare_field("col_minus_dx", want.col_minus_dx, got.col_minus_dx);
      compare_field("col_plus_dy",  want.col_plus_dy,  got.col_plus_dy);
      compare_field("col_minus_dy", want.col_minus_dy, got.col_minus_dy);
      compare_field("row_plus_dy",  want.row_plus_dy,  got.row_plus_dy);
      compare_field("row_minus_dy", want.row_minus_dy, got.row_minus_dy);
      compare_field("row_plus_dx",  want.row_plus_dx,  got.row_plus_dx);
      compare_field("row_minus_dx", want.row_minus_dx, got.row_minus_dx);
      compare_field("last",         want.last,         got.last);
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  req_t  in_data;
  logic  out_valid;
  logic  out_stall = 1'b0;
  pset_t out_data;

  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;

  circle_scoreboard sb = new();

  midpoint_circle_rasterizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_point_set(out_data);
  end

  function automatic req_t circle(int cx, int cy, int r);
    req_t rq;
    rq.center_x = COORD_W'(cx);
    rq.center_y = COORD_W'(cy);
    rq.radius   = COORD_W'(r);
    return rq;
  endfunction

  // Mostly on-display circles of modest size; some full-range and edge cases
  function automatic req_t random_request();
    req_t rq;
    int   sel;
    sel = $urandom_range(99);
    if (sel < 70) begin
      rq.center_x = COORD_W'($urandom_range(0, DISP_W - 1));
      rq.center_y = COORD_W'($urandom_range(0, DISP_H - 1));
      rq.radius   = ($urandom_range(99) < 85) ? COORD_W'($urandom_range(0, 24))
                                              : COORD_W'($urandom_range(0, 70));
    end else if (sel < 85) begin
      rq = req_t'(24'($urandom));
    end else begin
      rq.center_x = $urandom_range(1) ? COORD_W'($urandom_range(0, 7))
                                      : COORD_W'($urandom_range(DISP_W - 8, DISP_W + 7));
      rq.center_y = $urandom_range(1) ? COORD_W'($urandom_range(0, 7))
                                      : COORD_W'($urandom_range(DISP_H - 8, DISP_H + 7));
      rq.radius   = COORD_W'($urandom_range(0, 255));
    end
    return rq;
  endfunction

  // Entered and left at a falling edge
  task automatic send_request(req_t rq);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      in_data  = req_t'(24'($urandom));
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = rq;
    do @(posedge clk); while (in_stall);
    sb.rasterize_circle(rq);
    @(negedge clk);
  endtask

  initial begin
    int phase;
    int i;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    sender_idle_pct = 12;
    recv_stall_pct  = 62;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    send_request(circle(64, 32, 0));
    send_request(circle(200, 10, 0));
    send_request(circle(200, 100, 5));
    send_request(circle(64, 32, 1));
    send_request(circle(64, 32, 2));
    send_request(circle(64, 32, 3));
    send_request(circle(64, 32, 10));
    send_request(circle(64, 32, 31));
    send_request(circle(0, 0, 255));
    send_request(circle(127, 63, 255));
    send_request(circle(127, 63, 1));
    send_request(circle(255, 255, 255));
    send_request(circle(0, 0, 0));
    send_request(circle(255, 0, 1));
    send_request(circle(0, 63, 64));
    send_request(circle(100, 20, 200));
    send_request(circle(127, 0, 128));
    send_request(circle(126, 62, 2));
    send_request(circle(128, 64, 1));
    send_request(circle(0, 0, 1));
    send_request(circle(5, 5, 6));
    send_request(circle(5, 5, 7));
    send_request(circle(60, 30, 45));
    send_request(circle(32, 32, 32));

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 12;
          recv_stall_pct  = 62;
        end
        1: begin
          sender_idle_pct = 62;
          recv_stall_pct  = 12;
        end
        default: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
      endcase
      for (i = 0; i < RAND_PER_PHASE; i++) send_request(random_request());
    end
    in_valid = 1'b0;

    while (sb.pending_sets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("midpoint_circle_rasterizer_tb: PASS");
    end else begin
      $display("midpoint_circle_rasterizer_tb: FAIL");
    end
    $finish;
  end

  // well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d point sets outstanding", $time, sb.pending_sets.size());
    $display("midpoint_circle_rasterizer_tb: FAIL");
    $finish;
  end

endmodule
